/* design/crss_pkg.sv */
`default_nettype none

package crss_pkg;

   // fixed field widths of the result and configuration items
   localparam int POS_W     = 17;
   localparam int TAN_W     = 18;
   localparam int IDX_OUT_W = 6;
   localparam int CFG_W     = 7;

   // u is unsigned Q1.16, 0..65536
   localparam int U_W    = 17;
   localparam int U_FRAC = 16;

   localparam int AXES      = 3;
   localparam int WIN_DEPTH = 3;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd32;
   localparam logic [CFG_W-1:0] CFG_MIN   = 7'd2;

   typedef struct packed {
      logic div_start;
      logic accept;
      logic issue;
   } crss_cmd_type;

   typedef struct packed {
      logic csr_write;
      logic div_busy;
      logic run;
      logic last_issue;
      logic can_advance;
      logic pipe_empty;
   } crss_status_type;

endpackage

`default_nettype wire

/* design/crss_ifs.sv */
`default_nettype none

interface crss_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic                         new_curve;

   modport source (output valid, point_x, point_y, point_z, new_curve, input ready);
   modport sink   (input valid, point_x, point_y, point_z, new_curve, output ready);
endinterface

interface crss_rsp_if import crss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [POS_W-1:0]    pos_x;
   logic signed [POS_W-1:0]    pos_y;
   logic signed [POS_W-1:0]    pos_z;
   logic signed [TAN_W-1:0]    tan_x;
   logic signed [TAN_W-1:0]    tan_y;
   logic signed [TAN_W-1:0]    tan_z;
   logic [IDX_OUT_W-1:0]       sample_index;
   logic                       last_sample;

   modport source (output valid, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
                   sample_index, last_sample, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
                   sample_index, last_sample, output ready);
endinterface

interface crss_csr_if import crss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] samples_per_segment;

   modport source (output valid, samples_per_segment, input ready);
   modport sink   (input valid, samples_per_segment, output ready);
endinterface

`default_nettype wire

/* design/catmull_rom_segment_sampler.sv */
`default_nettype none

// channel  port  dir  payload
// -------  ----  ---  ----------------------------------------------------
// points   req   in   point_x, point_y, point_z (signed), new_curve
// samples  rsp   out  pos_x/y/z, tan_x/y/z (signed), sample_index, last_sample
// config   csr   in   samples_per_segment
//
// after reset and after every config transfer, the 2^16/(n-1) step divider runs
// (one quotient bit per cycle); req.ready stays low meanwhile.
// a point that only fills the window is stored and issues no samples.
// a point that closes a segment issues n samples, one per cycle while rsp is
// not stalled, then the 6-stage sample pipeline drains.
// a stalled rsp transfer freezes the whole sample pipeline.

module catmull_rom_segment_sampler import crss_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   crss_req_if.sink    req,
   crss_rsp_if.source  rsp,
   crss_csr_if.sink    csr
);

   crss_cmd_type    cmd;
   crss_status_type status;
   logic            req_ready;

   crss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   crss_dp #(
      .COORD_BITS  (COORD_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req),
      .rsp    (rsp),
      .csr    (csr)
   );

   assign req.ready = req_ready;

endmodule

`default_nettype wire

/* design/crss_div.sv */
`default_nettype none

// restoring divider for 2^16 / divisor, one quotient bit per cycle
module crss_div import crss_pkg::*; #(
   parameter int DIV_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  busy,
   output logic [U_W-1:0]        quotient,
   output logic [DIV_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(U_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [U_W-1:0]   quo_ff, quo_in;
   logic [DIV_W:0]   shifted;
   logic             fits;

   always_comb begin
      // the dividend has its only set bit at the top, so it enters on the first step
      shifted  = {rem_ff[DIV_W-1:0], (count_ff == '0)};
      fits     = shifted >= {1'b0, divisor};
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? (shifted - {1'b0, divisor}) : shifted;
         quo_in   = {quo_ff[U_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(U_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DIV_W-1:0];

endmodule

`default_nettype wire

/* design/crss_dp.sv */
`default_nettype none

module crss_dp import crss_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire crss_cmd_type cmd,
   output crss_status_type   status,
   crss_req_if.sink          req,
   crss_rsp_if.source        rsp,
   crss_csr_if.sink          csr
);

   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int CW     = COORD_BITS + 4;
   localparam int PW     = CW + U_W + 1;
   localparam int SW     = PW + 3;
   localparam int STAGES = 5;
   localparam int OUT_SH = U_FRAC + 1;

   // configuration and step constants
   logic [CFG_W-1:0] csr_ff, csr_in;
   logic [CFG_W-1:0] n_eff;
   logic [IDX_W-1:0] d;
   logic             div_busy;
   logic [U_W-1:0]   step_q;
   logic [IDX_W-1:0] step_r;

   always_comb begin
      if (csr_ff < CFG_MIN) begin
         n_eff = CFG_MIN;
      end else if (csr_ff > CFG_W'(MAX_SAMPLES)) begin
         n_eff = CFG_W'(MAX_SAMPLES);
      end else begin
         n_eff = csr_ff;
      end
      d      = IDX_W'(n_eff - CFG_W'(1));
      csr_in = csr.valid ? csr.samples_per_segment : csr_ff;
   end

   crss_div #(.DIV_W(IDX_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .divisor   (d),
      .busy      (div_busy),
      .quotient  (step_q),
      .remainder (step_r)
   );

   // point window
   logic signed [COORD_BITS-1:0] win_ff [WIN_DEPTH][AXES];
   logic signed [COORD_BITS-1:0] pt [AXES];
   logic [1:0]                   held_ff, held_in, eff_held;
   logic                         run;

   assign pt[0] = req.point_x;
   assign pt[1] = req.point_y;
   assign pt[2] = req.point_z;

   always_comb begin
      eff_held = req.new_curve ? 2'd0 : held_ff;
      run      = eff_held == 2'd3;
      held_in  = held_ff;
      if (cmd.accept) begin
         held_in = run ? held_ff : eff_held + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (run) begin
            for (int a = 0; a < AXES; a++) begin
               win_ff[0][a] <= win_ff[1][a];
               win_ff[1][a] <= win_ff[2][a];
               win_ff[2][a] <= pt[a];
            end
         end else begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
               if (eff_held == 2'(k)) begin
                  for (int a = 0; a < AXES; a++) begin
                     win_ff[k][a] <= pt[a];
                  end
               end
            end
         end
      end
   end

   // segment coefficients, latched when a segment starts
   logic signed [CW-1:0] c0_ff [AXES];
   logic signed [CW-1:0] c1_ff [AXES];
   logic signed [CW-1:0] c2_ff [AXES];
   logic signed [CW-1:0] c3_ff [AXES];

   for (genvar a = 0; a < AXES; a++) begin : g_coef
      logic signed [CW-1:0] q0, q1, q2, q3;
      always_comb begin
         q0 = CW'(win_ff[0][a]);
         q1 = CW'(win_ff[1][a]);
         q2 = CW'(win_ff[2][a]);
         q3 = CW'(pt[a]);
      end
      always_ff @(posedge clock) begin
         if (cmd.accept && run) begin
            c0_ff[a] <= q1 <<< 1;
            c1_ff[a] <= q2 - q0;
            c2_ff[a] <= (q0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - q3;
            c3_ff[a] <= q1 + (q1 <<< 1) - q0 - (q2 + (q2 <<< 1)) + q3;
         end
      end
   end

   // u generator: U = floor((i*2^16 + d/2) / d) kept as quotient and remainder
   logic [U_W-1:0]   q_ff, q_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W:0]   r_sum;
   logic             wrap;

   always_comb begin
      r_sum = {1'b0, r_ff} + {1'b0, step_r};
      wrap  = r_sum >= {1'b0, d};
      q_in  = q_ff;
      r_in  = r_ff;
      i_in  = i_ff;
      if (cmd.accept && run) begin
         q_in = '0;
         r_in = d >> 1;
         i_in = '0;
      end else if (cmd.issue) begin
         q_in = q_ff + step_q + U_W'(wrap);
         r_in = wrap ? IDX_W'(r_sum - {1'b0, d}) : IDX_W'(r_sum);
         i_in = i_ff + IDX_W'(1);
      end
   end

   // sample pipeline: u, u^2, u^3, products, sums, saturation
   logic                 adv;
   logic [STAGES-1:0]    v_ff;
   logic [IDX_W-1:0]     idx_ff [STAGES];
   logic                 last_ff [STAGES];
   logic [U_W-1:0]       u1_ff, u2_ff, u3_ff;
   logic [U_W-1:0]       sq2_ff, sq3_ff, cube3_ff;
   logic [2*U_W-1:0]     sq_prod, cube_prod;
   logic signed [PW-1:0] m1_ff [AXES];
   logic signed [PW-1:0] m2_ff [AXES];
   logic signed [PW-1:0] m3_ff [AXES];
   logic signed [PW-1:0] m4_ff [AXES];
   logic signed [PW-1:0] m5_ff [AXES];
   logic signed [SW-1:0] s_ff [AXES];
   logic signed [SW-1:0] t_ff [AXES];
   logic                 out_v_ff;
   logic [POS_W-1:0]     pos_ff [AXES];
   logic [TAN_W-1:0]     tan_ff [AXES];
   logic [IDX_W-1:0]     idx_out_ff;
   logic                 last_out_ff;

   assign adv       = !out_v_ff || rsp.ready;
   assign sq_prod   = u1_ff * u1_ff;
   assign cube_prod = sq2_ff * u2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         u1_ff      <= q_ff;
         idx_ff[0]  <= i_ff;
         last_ff[0] <= i_ff == d;
         for (int k = 1; k < STAGES; k++) begin
            idx_ff[k]  <= idx_ff[k-1];
            last_ff[k] <= last_ff[k-1];
         end
         u2_ff    <= u1_ff;
         sq2_ff   <= sq_prod[U_FRAC+U_W-1:U_FRAC];
         u3_ff    <= u2_ff;
         sq3_ff   <= sq2_ff;
         cube3_ff <= cube_prod[U_FRAC+U_W-1:U_FRAC];
         idx_out_ff  <= idx_ff[STAGES-1];
         last_out_ff <= last_ff[STAGES-1];
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      logic signed [U_W:0]  su, ssq, scube;
      logic signed [SW-1:0] s_sum, t_sum, s_sh, t_sh;
      logic                 s_fits, t_fits;
      logic [POS_W-1:0]     pos_sat;
      logic [TAN_W-1:0]     tan_sat;

      always_comb begin
         su    = $signed({1'b0, u3_ff});
         ssq   = $signed({1'b0, sq3_ff});
         scube = $signed({1'b0, cube3_ff});
         s_sum = (SW'(c0_ff[a]) <<< U_FRAC) + SW'(m1_ff[a]) + SW'(m2_ff[a])
                 + SW'(m3_ff[a]);
         t_sum = (SW'(c1_ff[a]) <<< U_FRAC) + (SW'(m4_ff[a]) <<< 1) + SW'(m5_ff[a])
                 + (SW'(m5_ff[a]) <<< 1);
         s_sh   = s_ff[a] >>> OUT_SH;
         t_sh   = t_ff[a] >>> OUT_SH;
         // in range when all bits above the field agree with its sign bit
         s_fits = (&s_sh[SW-1:POS_W-1]) || !(|s_sh[SW-1:POS_W-1]);
         t_fits = (&t_sh[SW-1:TAN_W-1]) || !(|t_sh[SW-1:TAN_W-1]);
         if (s_fits) begin
            pos_sat = s_sh[POS_W-1:0];
         end else begin
            pos_sat = s_sh[SW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
         end
         if (t_fits) begin
            tan_sat = t_sh[TAN_W-1:0];
         end else begin
            tan_sat = t_sh[SW-1] ? {1'b1, {(TAN_W-1){1'b0}}} : {1'b0, {(TAN_W-1){1'b1}}};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            m1_ff[a]  <= PW'(c1_ff[a] * su);
            m2_ff[a]  <= PW'(c2_ff[a] * ssq);
            m3_ff[a]  <= PW'(c3_ff[a] * scube);
            m4_ff[a]  <= PW'(c2_ff[a] * su);
            m5_ff[a]  <= PW'(c3_ff[a] * ssq);
            s_ff[a]   <= s_sum;
            t_ff[a]   <= t_sum;
            pos_ff[a] <= pos_sat;
            tan_ff[a] <= tan_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff   <= CFG_RESET;
         held_ff  <= 2'd0;
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         csr_ff  <= csr_in;
         held_ff <= held_in;
         if (adv) begin
            v_ff     <= {v_ff[STAGES-2:0], cmd.issue};
            out_v_ff <= v_ff[STAGES-1];
         end
      end
      q_ff <= q_in;
      r_ff <= r_in;
      i_ff <= i_in;
   end

   assign csr.ready = 1'b1;

   assign rsp.valid        = out_v_ff;
   assign rsp.pos_x        = pos_ff[0];
   assign rsp.pos_y        = pos_ff[1];
   assign rsp.pos_z        = pos_ff[2];
   assign rsp.tan_x        = tan_ff[0];
   assign rsp.tan_y        = tan_ff[1];
   assign rsp.tan_z        = tan_ff[2];
   assign rsp.sample_index = IDX_OUT_W'(idx_out_ff);
   assign rsp.last_sample  = last_out_ff;

   always_comb begin
      status.csr_write   = csr.valid;
      status.div_busy    = div_busy;
      status.run         = run;
      status.last_issue  = i_ff == d;
      status.can_advance = adv;
      status.pipe_empty  = !(|v_ff);
   end

endmodule

`default_nettype wire

/* design/crss_ctrl.sv */
`default_nettype none

module crss_ctrl import crss_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire crss_status_type status,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output crss_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_START,
      ST_DIV,
      ST_IDLE,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && status.run) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.can_advance && status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // coefficients stay in use until the last sample leaves the pipe
            if (status.pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_START;
         end
      endcase
      if (status.csr_write) begin
         state_in = ST_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_ready     = state_ff == ST_IDLE;
      cmd.div_start = state_ff == ST_START;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.issue     = (state_ff == ST_EMIT) && status.can_advance;
   end

endmodule

`default_nettype wire
